@@ rtl/core/mbrp_pkg.sv @@
// Shared types and constants for the 1-bit frame rotator.
`default_nettype none

package mbrp_pkg;

  // Register field widths
  localparam int unsigned WIDTH_W  = 9;
  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned STRIDE_W = 6;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Destination geometry
  localparam int unsigned MAX_COLS = 256;
  localparam int unsigned COL_W    = 8;
  localparam int unsigned IDX_W    = HEIGHT_W - 3;
  localparam int unsigned BIT_W    = 3;
  localparam int unsigned FS_W     = HEIGHT_W + STRIDE_W;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SRC_STRIDE   = 2'd2,
    REG_INVERT       = 2'd3
  } reg_idx_e;

  // Gather sequencer states
  typedef enum logic [1:0] {
    GTH_IDLE,
    GTH_RUN,
    GTH_FLUSH,
    GTH_HOLD
  } gth_state_e;

  // Per-transaction request handed to the gather sequencer
  typedef struct packed {
    logic                last;
    logic [BIT_W-1:0]    bitsel;
    logic [HEIGHT_W-1:0] rows_left;
    logic [STRIDE_W-1:0] stride;
    logic                invert;
  } gth_req_t;

endpackage

`default_nettype wire

@@ rtl/core/mbrp_ram.sv @@
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none

module mbrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mbrp_gather.sv @@
// Gather sequencer: reads up to eight source rows and packs one destination byte.
`default_nettype none

module mbrp_gather #(
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire mbrp_pkg::gth_req_t    req_i,
  input  wire logic [AW-1:0]         base_i,
  input  wire logic [AW-1:0]         xoff_i,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  wire logic [mbrp_pkg::DATA_W-1:0] rd_data_i,
  output logic                       busy_o,
  output logic                       res_valid_o,
  input  wire logic                  res_take_i,
  output logic [mbrp_pkg::DATA_W-1:0] res_byte_o,
  output logic                       res_last_o
);

  import mbrp_pkg::*;

  gth_state_e       state_q, state_d;
  logic [BIT_W-1:0] b_q;
  logic [AW-1:0]    base_q;
  logic [AW-1:0]    xoff_q;
  gth_req_t         req_q;
  logic             vld_d1_q;
  logic [BIT_W-1:0] bd1_q;
  logic [DATA_W-1:0] acc_q;

  logic             bit_ok;
  logic [AW:0]      addr_sum;

  // Row is inside the frame; padding rows are not read
  assign bit_ok = {{(HEIGHT_W-BIT_W){1'b0}}, b_q} < req_q.rows_left;

  // Row base plus column byte offset, folded back into the store
  assign addr_sum = {1'b0, base_q} + {1'b0, xoff_q};
  always_comb begin
    if (addr_sum >= (AW+1)'(DEPTH)) begin
      rd_addr_o = AW'(addr_sum - (AW+1)'(DEPTH));
    end else begin
      rd_addr_o = AW'(addr_sum);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      GTH_IDLE:  if (start_i) state_d = GTH_RUN;
      GTH_RUN:   if (b_q == BIT_W'(7)) state_d = GTH_FLUSH;
      GTH_FLUSH: state_d = GTH_HOLD;
      GTH_HOLD:  if (res_take_i) state_d = GTH_IDLE;
      default:   state_d = GTH_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    rd_en_o     = 1'b0;
    busy_o      = 1'b1;
    res_valid_o = 1'b0;
    case (state_q)
      GTH_IDLE:  busy_o = 1'b0;
      GTH_RUN:   rd_en_o = bit_ok;
      GTH_FLUSH: ;
      GTH_HOLD:  res_valid_o = 1'b1;
      default:   busy_o = 1'b0;
    endcase
  end

  assign res_byte_o = acc_q;
  assign res_last_o = req_q.last;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= GTH_IDLE;
      vld_d1_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      vld_d1_q <= rd_en_o;
    end
  end

  // Datapath: step through rows, at most one read issued and one bit packed per cycle
  always_ff @(posedge clk_i) begin
    bd1_q <= b_q;
    if (state_q == GTH_IDLE && start_i) begin
      b_q    <= '0;
      base_q <= base_i;
      xoff_q <= xoff_i;
      req_q  <= req_i;
      acc_q  <= '0;
    end else begin
      if (state_q == GTH_RUN) begin
        b_q    <= b_q + BIT_W'(1);
        base_q <= base_q - AW'(req_q.stride);
      end
      // first destination row lands in bit 7
      if (vld_d1_q) begin
        acc_q[~bd1_q] <= (rd_data_i[req_q.bitsel] == req_q.invert);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mono_bitmap_rotate_pack.sv @@
// Top level of the 1-bit frame rotator: registers, pointers, store and output stage.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid_i / in_stall_o   mode_i, src_byte_i
//   out       source     out_valid_o / out_stall_i dest_byte_o, last_byte_o
//   cfg       sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A load transaction (mode 0) writes the frame store in its accept cycle; the
// next transaction may follow in the next cycle.
// A read transaction (mode 1) runs through the accept cycle, up to eight reads
// of the single-read-port store (one per source row inside the frame), a flush
// state for the read latency and a hold state that hands the byte to the output register.
// out_stall_i holds the output register; the sequencer then holds its byte and in_stall_o holds off new transactions.
// Reset clears pointers and output valid and loads the configuration defaults; the store has no clearing pass.
`default_nettype none

module mono_bitmap_rotate_pack #(
  parameter int unsigned MAX_ROWS   = 128,
  parameter int unsigned MAX_STRIDE = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              mode_i,
  input  wire logic [mbrp_pkg::DATA_W-1:0]       src_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [mbrp_pkg::DATA_W-1:0]            dest_byte_o,
  output logic                                   last_byte_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mbrp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mbrp_pkg::WIDTH_W-1:0]      cfg_data_i
);

  import mbrp_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_STRIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = ((AW > FS_W) ? AW : FS_W) + 1;

  // Configuration registers
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [STRIDE_W-1:0] stride_q;
  logic                invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(250);
      height_q <= HEIGHT_W'(122);
      stride_q <= STRIDE_W'(32);
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        REG_SRC_STRIDE:   stride_q <= cfg_data_i[STRIDE_W-1:0];
        REG_INVERT:       invert_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) geometry
  logic [HEIGHT_W-1:0] eff_h;
  logic [STRIDE_W-1:0] eff_s;
  logic [WIDTH_W-1:0]  eff_w;
  logic [IDX_W:0]      byte_h;
  logic [FS_W-1:0]     frame_size;

  always_comb begin
    if (height_q == '0) begin
      eff_h = HEIGHT_W'(1);
    end else if (int'(height_q) > MAX_ROWS) begin
      eff_h = HEIGHT_W'(MAX_ROWS);
    end else begin
      eff_h = height_q;
    end
    if (stride_q == '0) begin
      eff_s = STRIDE_W'(1);
    end else if (int'(stride_q) > MAX_STRIDE) begin
      eff_s = STRIDE_W'(MAX_STRIDE);
    end else begin
      eff_s = stride_q;
    end
    if (width_q == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (width_q > WIDTH_W'(MAX_COLS)) begin
      eff_w = WIDTH_W'(MAX_COLS);
    end else begin
      eff_w = width_q;
    end
  end

  assign byte_h     = (IDX_W+1)'(({1'b0, eff_h} + (HEIGHT_W+1)'(7)) >> 3);
  assign frame_size = FS_W'(eff_h) * FS_W'(eff_s);

  // Handshake decode
  logic gth_busy;
  logic in_acc, wr_en, start;

  assign in_stall_o = gth_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wr_en      = in_acc && !mode_i;
  assign start      = in_acc && mode_i;

  // Load pointer, wraps at the end of the frame
  logic [AW-1:0] load_ptr_q, load_ptr_d;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] ptr_next;

  always_comb begin
    if (CW'(load_ptr_q) >= CW'(frame_size)) begin
      wr_addr = '0;
    end else begin
      wr_addr = load_ptr_q;
    end
    ptr_next = CW'(wr_addr) + CW'(1);
    if (ptr_next >= CW'(frame_size)) begin
      load_ptr_d = '0;
    end else begin
      load_ptr_d = AW'(ptr_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ptr_q <= '0;
    end else if (wr_en) begin
      load_ptr_q <= load_ptr_d;
    end
  end

  // Read position, restarted if it lies outside the current frame
  logic [COL_W-1:0] col_q, col_use, col_d;
  logic [IDX_W-1:0] idx_q, idx_use, idx_d;
  logic             last_use;

  always_comb begin
    if (WIDTH_W'(col_q) >= eff_w || (IDX_W+1)'(idx_q) >= byte_h) begin
      col_use = '0;
      idx_use = '0;
    end else begin
      col_use = col_q;
      idx_use = idx_q;
    end
    last_use = (WIDTH_W'(col_use) == eff_w - WIDTH_W'(1)) &&
               ((IDX_W+1)'(idx_use) == byte_h - (IDX_W+1)'(1));
    if ((IDX_W+1)'(idx_use) + (IDX_W+1)'(1) >= byte_h) begin
      idx_d = '0;
      if (WIDTH_W'(col_use) + WIDTH_W'(1) >= eff_w) begin
        col_d = '0;
      end else begin
        col_d = col_use + COL_W'(1);
      end
    end else begin
      idx_d = idx_use + IDX_W'(1);
      col_d = col_use;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      idx_q <= '0;
    end else if (start) begin
      col_q <= col_d;
      idx_q <= idx_d;
    end
  end

  // Column byte offset taken modulo the store depth
  function automatic logic [AW-1:0] mod_depth(input logic [COL_W-4:0] v);
    logic [COL_W-4:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (int'(r) >= DEPTH) r = r - (COL_W-3)'(DEPTH);
    end
    return AW'(r);
  endfunction

  // Request for the gather sequencer
  gth_req_t            req;
  logic [HEIGHT_W-1:0] rows_left;
  logic [FS_W-1:0]     base_full;
  logic [AW-1:0]       xoff;

  assign rows_left = eff_h - {idx_use, 3'b000};
  assign base_full = FS_W'(rows_left - HEIGHT_W'(1)) * FS_W'(eff_s);
  assign xoff      = mod_depth(col_use[COL_W-1:3]);

  assign req.last      = last_use;
  assign req.bitsel    = col_use[2:0];
  assign req.rows_left = rows_left;
  assign req.stride    = eff_s;
  assign req.invert    = invert_q;

  // Frame store
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  mbrp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (src_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  logic              res_valid, res_take, res_last;
  logic [DATA_W-1:0] res_byte;

  mbrp_gather #(
    .DEPTH (DEPTH)
  ) u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req),
    .base_i      (AW'(base_full)),
    .xoff_i      (xoff),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .busy_o      (gth_busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_byte_o  (res_byte),
    .res_last_o  (res_last)
  );

  // Output register
  logic out_valid_q;

  assign res_take    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      dest_byte_o <= res_byte;
      last_byte_o <= res_last;
    end
  end

endmodule

`default_nettype wire
